### src/psmp_pkg.sv
package psmp_pkg;

    // parser states of panel mode
    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_PRESS   = 4'd1,
        ST_RELEASE = 4'd2,
        ST_VERSION = 4'd3,
        ST_IDENT   = 4'd4,
        ST_PAGE    = 4'd5,
        ST_MEMORY  = 4'd6,
        ST_ICONS   = 4'd7,
        ST_FIELDS  = 4'd8,
        ST_PERR    = 4'd9,
        ST_SWITCH  = 4'd10,
        ST_IP      = 4'd11
    } parse_state_t;

    // result kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_KEY   = 3'd1;
    localparam logic [2:0] KIND_INFO  = 3'd2;
    localparam logic [2:0] KIND_CARD  = 3'd3;
    localparam logic [2:0] KIND_ACK   = 3'd4;
    localparam logic [2:0] KIND_ENTER = 3'd5;
    localparam logic [2:0] KIND_LEAVE = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_LINE     = 3'd1;
    localparam logic [2:0] ERR_LEAD     = 3'd2;
    localparam logic [2:0] ERR_INTERNAL = 3'd3;
    localparam logic [2:0] ERR_PANEL    = 3'd4;
    localparam logic [2:0] ERR_SWITCH   = 3'd5;

    // info field codes
    localparam logic [2:0] FLD_VERSION = 3'd0;
    localparam logic [2:0] FLD_IDENT   = 3'd1;
    localparam logic [2:0] FLD_PAGE    = 3'd2;
    localparam logic [2:0] FLD_MEMORY  = 3'd3;
    localparam logic [2:0] FLD_ICONS   = 3'd4;
    localparam logic [2:0] FLD_FIELDS  = 3'd5;
    localparam logic [2:0] FLD_IP      = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_BREAK_READY = 2'd0;
    localparam logic [1:0] CFG_BAUD_READY  = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd2;
    localparam logic [1:0] CFG_SWITCH_BYTE = 2'd3;

    localparam logic [7:0] ESCAPE_RESET = 8'd27;
    localparam logic [7:0] SWITCH_RESET = 8'd3;

    // characters of the panel protocol
    localparam logic [7:0] CH_PRESS   = 8'h52;  // 'R'
    localparam logic [7:0] CH_RELEASE = 8'h72;  // 'r'
    localparam logic [7:0] CH_VERSION = 8'h56;  // 'V'
    localparam logic [7:0] CH_IDENT   = 8'h69;  // 'i'
    localparam logic [7:0] CH_PAGE    = 8'h41;  // 'A'
    localparam logic [7:0] CH_MEMORY  = 8'h4D;  // 'M'
    localparam logic [7:0] CH_IP      = 8'h4E;  // 'N'
    localparam logic [7:0] CH_ICONS   = 8'h70;  // 'p'
    localparam logic [7:0] CH_FIELDS  = 8'h74;  // 't'
    localparam logic [7:0] CH_PERR    = 8'h45;  // 'E'
    localparam logic [7:0] CH_SKIP    = 8'h53;  // 'S'
    localparam logic [7:0] CH_ACK     = 8'h06;
    localparam logic [7:0] CH_SW1     = 8'h0F;
    localparam logic [7:0] CH_SW2     = 8'h0E;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] KEY_NONE   = 8'hFF;

    typedef struct packed {
        logic       break_ready;
        logic       baud_ready;
        logic [7:0] escape_byte;
        logic [7:0] switch_byte;
    } cfg_t;

    // running decimal value, stop set once a non-digit ended it
    typedef struct packed {
        logic       stop;
        logic [7:0] val;
    } digit_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [2:0] info_field;
        logic [3:0] info_index;
        logic       info_last;
        logic [2:0] error_code;
        logic [6:0] panel_error;
        logic       card_mode;
    } result_t;

    // one decimal digit step, value kept modulo 256
    function automatic digit_t num_feed(digit_t acc, logic [7:0] c);
        digit_t r;
        logic [7:0] d;
        r = acc;
        d = c - 8'h30;
        if (!acc.stop) begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r.val = {acc.val[4:0], 3'b000} + {acc.val[6:0], 1'b0} + d;
            end else begin
                r.stop = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

### src/panel_serial_message_parser.sv
// path: input register, combinational parser step, result register on m_*
// throughput: one byte per cycle, one result per byte, while m_ready drains
//   the result register; the parser state registers update with each moved beat
// reset: synchronous active-low aresetn clears both valid flags, the parser
//   state and the configuration registers (escape 27, switch 3)
module panel_serial_message_parser #(
    parameter int IP_MAX = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_line_error,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_value,
    output logic [2:0] m_info_field,
    output logic [3:0] m_info_index,
    output logic       m_info_last,
    output logic [2:0] m_error_code,
    output logic [6:0] m_panel_error,
    output logic       m_card_mode,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);
    import psmp_pkg::*;

    cfg_t       cfg;
    result_t    res;
    result_t    out_reg;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_err_reg;
    logic       out_vld_reg;
    logic       advance;

    // configuration registers
    psmp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // a beat moves on when the output register is free or drained
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_err_reg  <= s_line_error;
        end
    end

    psmp_core #(
        .IP_MAX (IP_MAX)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .line_error (in_err_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_kind        = out_reg.kind;
    assign m_value       = out_reg.value;
    assign m_info_field  = out_reg.info_field;
    assign m_info_index  = out_reg.info_index;
    assign m_info_last   = out_reg.info_last;
    assign m_error_code  = out_reg.error_code;
    assign m_panel_error = out_reg.panel_error;
    assign m_card_mode   = out_reg.card_mode;

endmodule

### src/psmp_cfg_regs.sv
module psmp_cfg_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_wdata,
    output psmp_pkg::cfg_t  cfg
);
    import psmp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_BREAK_READY: cfg_next.break_ready = cfg_wdata[0];
                CFG_BAUD_READY:  cfg_next.baud_ready  = cfg_wdata[0];
                CFG_ESCAPE_BYTE: cfg_next.escape_byte = cfg_wdata;
                CFG_SWITCH_BYTE: cfg_next.switch_byte = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.break_ready <= 1'b0;
            cfg_reg.baud_ready  <= 1'b0;
            cfg_reg.escape_byte <= ESCAPE_RESET;
            cfg_reg.switch_byte <= SWITCH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/psmp_core.sv
module psmp_core #(
    parameter int IP_MAX = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              line_error,
    input  psmp_pkg::cfg_t    cfg,
    output psmp_pkg::result_t res
);
    import psmp_pkg::*;

    localparam int CW = $clog2(IP_MAX);
    localparam logic [CW-1:0] IP_LIMIT = CW'(IP_MAX - 1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    parse_state_t  st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    digit_t        acc_reg, acc_next;
    logic          card_reg, card_next;
    logic          esc_reg, esc_next;

    logic [31:0]   cnt_wide;
    logic [2:0]    fld;
    logic [2:0]    last_idx;
    logic          done;
    digit_t        fed;

    assign cnt_wide = 32'(cnt_reg);
    assign fed      = num_feed(acc_reg, rx_byte);

    // field code and final index of fixed-length info strings
    always_comb begin
        case (st_reg)
            ST_VERSION: begin fld = FLD_VERSION; last_idx = 3'd7; end
            ST_IDENT:   begin fld = FLD_IDENT;   last_idx = 3'd7; end
            ST_PAGE:    begin fld = FLD_PAGE;    last_idx = 3'd2; end
            ST_MEMORY:  begin fld = FLD_MEMORY;  last_idx = 3'd4; end
            ST_ICONS:   begin fld = FLD_ICONS;   last_idx = 3'd2; end
            ST_FIELDS:  begin fld = FLD_FIELDS;  last_idx = 3'd2; end
            default:    begin fld = FLD_IP;      last_idx = 3'd0; end
        endcase
        done = (cnt_reg >= CW'(last_idx));
    end

    // per-byte parse: next state and result
    always_comb begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        card_next = card_reg;
        esc_next  = esc_reg;
        res       = '0;
        if (card_reg) begin
            // card mode unstuffing
            if (line_error) begin
                card_next      = 1'b0;
                st_next        = ST_IDLE;
                res.kind       = KIND_LEAVE;
                res.error_code = ERR_LINE;
            end else if (rx_byte == cfg.escape_byte) begin
                if (esc_reg) begin
                    esc_next  = 1'b0;
                    res.kind  = KIND_CARD;
                    res.value = rx_byte;
                end else begin
                    esc_next = 1'b1;
                end
            end else if (rx_byte == cfg.switch_byte && esc_reg) begin
                esc_next  = 1'b0;
                card_next = 1'b0;
                res.kind  = KIND_LEAVE;
            end else begin
                res.kind  = KIND_CARD;
                res.value = rx_byte;
            end
        end else if (line_error) begin
            st_next   = ST_IDLE;
            res.kind  = KIND_KEY;
            res.value = KEY_NONE;
            if (cfg.break_ready) begin
                res.error_code = ERR_LINE;
            end
        end else if (cfg.baud_ready) begin
            case (st_reg)
                ST_IDLE: begin
                    // lead character decode
                    cnt_next = '0;
                    acc_next = '0;
                    case (rx_byte)
                        CH_PRESS:   st_next = ST_PRESS;
                        CH_RELEASE: st_next = ST_RELEASE;
                        CH_VERSION: begin
                            res.kind       = KIND_INFO;
                            res.value      = rx_byte;
                            res.info_field = FLD_VERSION;
                            cnt_next       = CNT_ONE;
                            st_next        = ST_VERSION;
                        end
                        CH_IDENT:   st_next = ST_IDENT;
                        CH_PAGE:    st_next = ST_PAGE;
                        CH_MEMORY:  st_next = ST_MEMORY;
                        CH_IP:      st_next = ST_IP;
                        CH_ICONS:   st_next = ST_ICONS;
                        CH_FIELDS:  st_next = ST_FIELDS;
                        CH_PERR:    st_next = ST_PERR;
                        CH_SKIP:    st_next = ST_IDLE;
                        CH_ACK:     res.kind = KIND_ACK;
                        CH_SW1:     st_next = ST_SWITCH;
                        default: begin
                            if (cfg.break_ready) begin
                                res.error_code = ERR_LEAD;
                            end
                        end
                    endcase
                end
                ST_PRESS, ST_RELEASE: begin
                    // three key digits, the third digit finishes the code
                    if (cnt_reg >= CW'(2)) begin
                        res.kind = KIND_KEY;
                        if (st_reg == ST_RELEASE || fed.val == 8'd0) begin
                            res.value = KEY_NONE;
                        end else begin
                            res.value = fed.val;
                        end
                        st_next = ST_IDLE;
                    end else begin
                        acc_next = fed;
                        cnt_next = cnt_reg + CNT_ONE;
                    end
                end
                ST_VERSION, ST_IDENT, ST_PAGE, ST_MEMORY, ST_ICONS, ST_FIELDS: begin
                    res.kind       = KIND_INFO;
                    res.value      = rx_byte;
                    res.info_field = fld;
                    res.info_index = cnt_wide[3:0];
                    res.info_last  = done;
                    if (done) begin
                        st_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + CNT_ONE;
                    end
                end
                ST_PERR: begin
                    // waits here until error reporting is on; the byte taken then is the second digit
                    if (cnt_reg >= CNT_ONE) begin
                        if (cfg.break_ready) begin
                            res.error_code  = ERR_PANEL;
                            res.panel_error = fed.val[6:0];
                            st_next         = ST_IDLE;
                        end
                    end else begin
                        acc_next = fed;
                        cnt_next = CNT_ONE;
                    end
                end
                ST_SWITCH: begin
                    if (rx_byte == CH_SW2) begin
                        card_next = 1'b1;
                        res.kind  = KIND_ENTER;
                    end else begin
                        res.error_code = ERR_SWITCH;
                    end
                    st_next = ST_IDLE;
                end
                ST_IP: begin
                    if (rx_byte == CH_IDENT) begin
                        cnt_next = '0;
                    end else if (rx_byte == CH_CR) begin
                        res.kind       = KIND_INFO;
                        res.info_field = FLD_IP;
                        res.info_index = cnt_wide[3:0];
                        res.info_last  = 1'b1;
                        st_next        = ST_IDLE;
                    end else if (cnt_reg < IP_LIMIT) begin
                        res.kind       = KIND_INFO;
                        res.value      = rx_byte;
                        res.info_field = FLD_IP;
                        res.info_index = cnt_wide[3:0];
                        cnt_next       = cnt_reg + CNT_ONE;
                    end
                end
                default: begin
                    if (cfg.break_ready) begin
                        res.error_code = ERR_INTERNAL;
                        st_next        = ST_IDLE;
                    end
                end
            endcase
        end
        res.card_mode = card_next;
    end

    // parser state advances once per processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            card_reg <= 1'b0;
            esc_reg  <= 1'b0;
        end else if (step) begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            card_reg <= card_next;
            esc_reg  <= esc_next;
        end
    end

endmodule

### src/psmp_checker.sv
module psmp_assert (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [7:0] m_value,
    input logic [2:0] m_error_code,
    input logic [6:0] m_panel_error,
    input logic       m_card_mode
);
    import psmp_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value))
        else $error("result beat changed while stalled");

    // entering card mode leaves the block in card mode
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ENTER |-> m_card_mode)
        else $error("enter card without card mode");

    // leaving card mode leaves the block in panel mode
    a_leave: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_LEAVE |-> !m_card_mode)
        else $error("leave card while still in card mode");

    // card data only comes out in card mode
    a_card: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_CARD |-> m_card_mode)
        else $error("card byte outside card mode");

    // panel error number only with a panel-reported error
    a_perr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_PANEL |-> m_panel_error == 7'd0)
        else $error("panel error number without panel error code");

endmodule

bind panel_serial_message_parser psmp_assert u_psmp_assert (.*);
